// ===== hw/rtl/elp_pkg.sv =====
// Shared types and constants for the edge list text parser.
// Used by elp_front, elp_fifo, elp_back and edge_list_text_parser.
package elp_pkg;

  // Default width of the decimal value accumulator.
  localparam int unsigned VALUE_BITS_DEF = 31;

  // Entries in the queue between the classifier and the parser.
  localparam int unsigned FIFO_DEPTH = 4;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned VERTEX_W    = 32;
  localparam int unsigned LARGEST_W   = 31;

  // Character codes the parser reacts to.
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Byte classes produced by the front end.
  typedef enum logic [1:0] {
    CLS_OTHER   = 2'd0,
    CLS_DIGIT   = 2'd1,
    CLS_MINUS   = 2'd2,
    CLS_NEWLINE = 2'd3
  } byte_cls_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    byte_cls_e   cls;
    logic [3:0]  digit;
    logic        last;
  } item_t;

endpackage

// ===== hw/rtl/elp_front.sv =====
// Front end of the edge list text parser: accepts bytes and classifies them.
// Depends on elp_pkg; feeds elp_fifo.
module elp_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [elp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic                            s_axis_tlast,  // last_byte
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output elp_pkg::item_t                  item_o
);
  import elp_pkg::*;

  logic [7:0] digit_off;

  // Accept a byte whenever the queue has room.
  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;

  // Classify the byte and extract its digit value.
  assign digit_off = s_axis_tdata - CHAR_ZERO;

  always_comb begin
    item_o.last  = s_axis_tlast;
    item_o.digit = digit_off[3:0];
    priority if (s_axis_tdata >= CHAR_ZERO && s_axis_tdata <= CHAR_NINE) begin
      item_o.cls = CLS_DIGIT;
    end else if (s_axis_tdata == CHAR_MINUS) begin
      item_o.cls = CLS_MINUS;
    end else if (s_axis_tdata == CHAR_NEWLINE) begin
      item_o.cls = CLS_NEWLINE;
    end else begin
      item_o.cls = CLS_OTHER;
    end
  end

endmodule

// ===== hw/rtl/elp_fifo.sv =====
// Short queue of classified bytes between the front end and the parser.
// Depends on elp_pkg for the item type.
module elp_fifo #(
  parameter int unsigned DEPTH = elp_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  elp_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output elp_pkg::item_t head_o
);
  import elp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Queue sanity.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/elp_back.sv =====
// Back end of the edge list text parser: number parsing state machine and result register.
// Depends on elp_pkg; consumes items from elp_fifo.
module elp_back #(
  parameter int unsigned VALUE_BITS = elp_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  elp_pkg::item_t                  item_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [elp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import elp_pkg::*;

  localparam int unsigned VB   = VALUE_BITS;
  localparam int unsigned WIDE = (VB > VERTEX_W) ? VB : VERTEX_W;

  typedef enum logic [5:0] {
    PH_SEEK1    = 6'b000001,
    PH_NUM1     = 6'b000010,
    PH_SEEK2    = 6'b000100,
    PH_NUM2     = 6'b001000,
    PH_SKIPLINE = 6'b010000,
    PH_HALT     = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            minus_q, minus_d;
  logic [VB-1:0]   first_q, first_d;
  logic [VB-1:0]   acc_q, acc_d;
  logic [VB-1:0]   max_q, max_d;

  logic            out_valid_q, out_valid_d;
  logic            out_edge_q;
  logic            out_done_q;
  logic [VERTEX_W-1:0]  out_src_q, out_src_d;
  logic [VERTEX_W-1:0]  out_tgt_q, out_tgt_d;
  logic [LARGEST_W-1:0] out_max_q, out_max_d;

  logic            is_dig, is_minus, is_nl, starts;
  logic [VB-1:0]   start_acc;
  logic [VB+3:0]   acc_wide;
  logic [VB-1:0]   acc_next;
  logic            acc_negative;
  phase_e          phase_n;
  logic            minus_n;
  logic [VB-1:0]   first_n, acc_n;
  logic            normal_finish, finish, pair;
  logic [VB-1:0]   max_a, max_n;
  logic [WIDE-1:0] src_wide, tgt_wide, max_wide;

  // Take the next byte whenever the result register is free or draining.
  assign pop_o = item_valid_i && (!out_valid_q || m_axis_tready);

  // Byte decode helpers.
  assign is_dig    = (item_i.cls == CLS_DIGIT);
  assign is_minus  = (item_i.cls == CLS_MINUS);
  assign is_nl     = (item_i.cls == CLS_NEWLINE);
  assign starts    = is_dig || is_minus;
  assign start_acc = is_dig ? VB'(item_i.digit) : '0;

  // Multiply by ten and add the digit, saturating at all ones.
  assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + (VB + 4)'(item_i.digit);
  assign acc_next     = (|acc_wide[VB+3:VB]) ? '1 : acc_wide[VB-1:0];
  assign acc_negative = minus_q && (acc_q != '0);

  // Parsing state machine for one byte.
  always_comb begin
    phase_n       = phase_q;
    minus_n       = minus_q;
    first_n       = first_q;
    acc_n         = acc_q;
    normal_finish = 1'b0;
    unique case (phase_q)
      PH_SEEK1, PH_SEEK2: begin
        if (starts) begin
          acc_n   = start_acc;
          minus_n = is_minus;
          phase_n = (phase_q == PH_SEEK1) ? PH_NUM1 : PH_NUM2;
        end
      end
      PH_NUM1: begin
        if (is_dig) begin
          acc_n = acc_next;
        end else if (acc_negative) begin
          phase_n = PH_HALT;
        end else begin
          first_n = acc_q;
          if (starts) begin
            acc_n   = start_acc;
            minus_n = is_minus;
            phase_n = PH_NUM2;
          end else begin
            phase_n = PH_SEEK2;
          end
        end
      end
      PH_NUM2: begin
        if (is_dig) begin
          acc_n = acc_next;
        end else begin
          normal_finish = 1'b1;
        end
      end
      PH_SKIPLINE: begin
        if (is_nl) begin
          phase_n = PH_SEEK1;
        end
      end
      default: begin
        phase_n = PH_HALT;
      end
    endcase
  end

  // Finishing the second number, either on its terminator or on the last byte.
  assign finish = normal_finish || (item_i.last && phase_n == PH_NUM2);
  assign pair   = finish && !(minus_n && (acc_n != '0));

  assign max_a = (first_n > max_q) ? first_n : max_q;
  assign max_n = pair ? ((acc_n > max_a) ? acc_n : max_a) : max_q;

  assign src_wide = WIDE'(first_n) - WIDE'(1);
  assign tgt_wide = WIDE'(acc_n) - WIDE'(1);
  assign max_wide = WIDE'(max_n);

  // Next state, cleared after the last byte of a buffer.
  always_comb begin
    phase_d = phase_q;
    minus_d = minus_q;
    first_d = first_q;
    acc_d   = acc_q;
    max_d   = max_q;
    if (pop_o) begin
      if (item_i.last) begin
        phase_d = PH_SEEK1;
        minus_d = 1'b0;
        first_d = '0;
        acc_d   = '0;
        max_d   = '0;
      end else begin
        minus_d = minus_n;
        first_d = first_n;
        acc_d   = acc_n;
        max_d   = max_n;
        if (finish) begin
          phase_d = !pair ? PH_HALT : (is_nl ? PH_SEEK1 : PH_SKIPLINE);
        end else begin
          phase_d = phase_n;
        end
      end
    end
  end

  // Result register contents.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (pop_o) begin
      out_valid_d = pair || item_i.last;
    end
    out_src_d = pair ? src_wide[VERTEX_W-1:0] : '0;
    out_tgt_d = pair ? tgt_wide[VERTEX_W-1:0] : '0;
    out_max_d = max_wide[LARGEST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK1;
      minus_q     <= 1'b0;
      first_q     <= '0;
      acc_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      minus_q     <= minus_d;
      first_q     <= first_d;
      acc_q       <= acc_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload loads whenever a byte is taken from the queue.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_edge_q <= pair;
      out_done_q <= item_i.last;
      out_src_q  <= out_src_d;
      out_tgt_q  <= out_tgt_d;
      out_max_q  <= out_max_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_edge_q;
  assign m_axis_tlast  = out_done_q;
  assign m_axis_tdata  = {1'b0, out_max_q, out_tgt_q, out_src_q};

  // Parser invariants.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> phase_q == PH_SEEK1 && max_q == '0 && acc_q == '0)
    else $error("state not cleared after last byte");
  a_halt_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && phase_q == PH_HALT && !item_i.last |=> phase_q == PH_HALT)
    else $error("parser left halt before last byte");
  a_no_edge_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_edge_q |-> out_src_q == '0 && out_tgt_q == '0 && out_done_q)
    else $error("non-pair request without zero vertices and done");
  a_max_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(max_q))
    else $error("maximum changed without a byte");

endmodule

// ===== hw/rtl/edge_list_text_parser.sv =====
// Top level of the edge list text parser: classifier, queue and parser back end.
// Depends on elp_pkg, elp_front, elp_fifo and elp_back.
//
//  Channel   Dir  Payload (tdata / tuser / tlast)
//  s_axis    in   text_byte / - / last_byte
//  m_axis    out  source, target, largest_vertex / edge_valid / stream_done
//
// One byte is accepted per cycle while the queue has room; a request for a byte passes
// through the queue write, then the parser state update into the result register.
// The multiply-by-ten accumulate and maximum compare in the back end set the clock path.
// Reset is asynchronous, active low, and returns the parser to seeking the first number.
// A stall on m_axis fills the four-entry queue before s_axis tready drops.
module edge_list_text_parser #(
  parameter int unsigned VALUE_BITS = elp_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [elp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic                            s_axis_tlast,   // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] source_vertex, [63:32] target_vertex, [94:64] largest_vertex, [95] zero
  output logic [elp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,   // edge_valid
  output logic                            m_axis_tlast    // stream_done
);
  import elp_pkg::*;

  logic  push, full, pop, head_valid;
  item_t push_item, head_item;

  elp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full_i   (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  elp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_item)
  );

  elp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (head_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
